/* hw/rtl/pcd_pkg.sv */
// ----------------------------------------------------------------------------
// pcd_pkg: shared types and constants of the pwm co2 period decoder
// status codes, register indexes, reset values and controller/datapath links
// ----------------------------------------------------------------------------
package pcd_pkg;

  // time counter width default
  localparam int TIME_WIDTH_DEF = 16;

  // field widths
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int PPM_W     = 14;
  localparam int OUT_T_W   = 16;
  localparam int STATUS_W  = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SNAP_LOW    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SNAP_HIGH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SNAP_TARGET = 3'd4;

  // register reset values
  localparam logic [CFG_W-1:0] TIMEOUT_RST     = 16'd2500;
  localparam logic [PPM_W-1:0] FULL_SCALE_RST  = 14'd5000;
  localparam logic [PPM_W-1:0] SNAP_LOW_RST    = 14'd385;
  localparam logic [PPM_W-1:0] SNAP_HIGH_RST   = 14'd399;
  localparam logic [PPM_W-1:0] SNAP_TARGET_RST = 14'd400;

  // ppm ceiling
  localparam logic [PPM_W-1:0] PPM_MAX = 14'd10000;

  // offsets applied to numerator and denominator
  localparam int NUM_OFS = 2;
  localparam int DEN_OFS = 4;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_TIMEOUT   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BADPERIOD = 2'd2;
  localparam logic [STATUS_W-1:0] ST_SAT       = 2'd3;

  // controller to datapath commands
  typedef struct packed {
    logic clear;
    logic tick;
    logic cap_high;
    logic cap_low;
    logic cap_end;
    logic div_start;
    logic load_timeout;
    logic load_bad;
    logic load_ok;
  } pcd_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic timeout_hit;
    logic den_bad;
    logic div_done;
  } pcd_sts_t;

endpackage

/* hw/rtl/pcd_div.sv */
// ----------------------------------------------------------------------------
// pcd_div: restoring divider, one quotient bit per cycle
// unsigned dividend over unsigned non-zero divisor, done pulses when finished
// ----------------------------------------------------------------------------
module pcd_div #(
  parameter int DW = 30,
  parameter int VW = 17
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CW = $clog2(DW);

  logic          busy;
  logic [VW-1:0] rem;
  logic [DW-1:0] quot;
  logic [VW-1:0] dsr;
  logic [CW-1:0] cnt;
  logic [VW:0]   shifted;
  logic [VW:0]   diff;
  logic          ge;
  logic          last;

  assign shifted  = {rem, quot[DW-1]};
  assign diff     = shifted - {1'b0, dsr};
  assign ge       = shifted >= {1'b0, dsr};
  assign last     = cnt == CW'(DW - 1);
  assign quotient = quot;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && last) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quot <= dividend;
      dsr  <= divisor;
      cnt  <= '0;
    end else if (busy) begin
      rem  <= ge ? diff[VW-1:0] : shifted[VW-1:0];
      quot <= {quot[DW-2:0], ge};
      cnt  <= cnt + 1'b1;
    end
  end

endmodule

/* hw/rtl/pcd_dpath.sv */
// ----------------------------------------------------------------------------
// pcd_dpath: datapath of the period decoder
// config registers, tick timers, multiplier, divider and result registers
// ----------------------------------------------------------------------------
module pcd_dpath #(
  parameter int TIME_WIDTH = pcd_pkg::TIME_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [pcd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pcd_pkg::CFG_W-1:0]     cfg_wdata,
  input  pcd_pkg::pcd_cmd_t             cmd,
  output pcd_pkg::pcd_sts_t             sts,
  output logic [pcd_pkg::PPM_W-1:0]     ppm,
  output logic [pcd_pkg::OUT_T_W-1:0]   high_time,
  output logic [pcd_pkg::OUT_T_W-1:0]   low_time,
  output logic [pcd_pkg::STATUS_W-1:0]  status
);

  import pcd_pkg::*;

  localparam int TW = TIME_WIDTH;
  localparam int PW = TW + PPM_W;   // product and quotient width
  localparam int VW = TW + 1;       // denominator width

  // config registers
  logic [CFG_W-1:0] timeout_ticks;
  logic [PPM_W-1:0] full_scale_ppm;
  logic [PPM_W-1:0] snap_low;
  logic [PPM_W-1:0] snap_high;
  logic [PPM_W-1:0] snap_target;

  // timers
  logic [TW-1:0] elapsed;
  logic [TW-1:0] high_start;
  logic [TW-1:0] low_start;
  logic [TW-1:0] high_dur;
  logic [TW-1:0] low_dur;
  logic          neg;

  logic [TW+15:0] elapsed_ext;
  logic [TW+15:0] timeout_ext;
  logic [TW+15:0] high_ext;
  logic [TW+15:0] low_ext;
  logic [VW-1:0]  dur_sum;
  logic [VW-1:0]  den;
  logic [TW-1:0]  num_mag;
  logic [PW-1:0]  product;
  logic [PW-1:0]  quot;
  logic           div_done;
  logic [PW-1:0]  snap_low_ext;
  logic [PW-1:0]  snap_high_ext;
  logic [PW-1:0]  snapped;
  logic           sat_high;
  logic [PPM_W-1:0]    ppm_calc;
  logic [STATUS_W-1:0] st_calc;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks  <= TIMEOUT_RST;
      full_scale_ppm <= FULL_SCALE_RST;
      snap_low       <= SNAP_LOW_RST;
      snap_high      <= SNAP_HIGH_RST;
      snap_target    <= SNAP_TARGET_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_TIMEOUT:     timeout_ticks  <= cfg_wdata;
        REG_FULL_SCALE:  full_scale_ppm <= cfg_wdata[PPM_W-1:0];
        REG_SNAP_LOW:    snap_low       <= cfg_wdata[PPM_W-1:0];
        REG_SNAP_HIGH:   snap_high      <= cfg_wdata[PPM_W-1:0];
        REG_SNAP_TARGET: snap_target    <= cfg_wdata[PPM_W-1:0];
        default: ;
      endcase
    end
  end

  // elapsed counter saturates, captures use the count before the tick
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      elapsed    <= '0;
      high_start <= '0;
      low_start  <= '0;
      high_dur   <= '0;
    end else begin
      if (cmd.tick && (elapsed != '1)) begin
        elapsed <= elapsed + 1'b1;
      end
      if (cmd.cap_high) begin
        high_start <= elapsed;
      end
      if (cmd.cap_low) begin
        low_start <= elapsed;
        high_dur  <= elapsed - high_start;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_end) begin
      low_dur <= elapsed - low_start;
    end
    if (cmd.div_start) begin
      neg <= high_dur < TW'(NUM_OFS);
    end
  end

  assign elapsed_ext = {16'b0, elapsed};
  assign timeout_ext = {{TW{1'b0}}, timeout_ticks};
  assign high_ext    = {16'b0, high_dur};
  assign low_ext     = {16'b0, low_dur};

  // period check and operands
  assign dur_sum = {1'b0, high_dur} + {1'b0, low_dur};
  assign den     = dur_sum - VW'(DEN_OFS);
  assign num_mag = (high_dur < TW'(NUM_OFS)) ? (TW'(NUM_OFS) - high_dur)
                                             : (high_dur - TW'(NUM_OFS));
  assign product = {{TW{1'b0}}, full_scale_ppm} * {{PPM_W{1'b0}}, num_mag};

  pcd_div #(
    .DW(PW),
    .VW(VW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (product),
    .divisor  (den),
    .done     (div_done),
    .quotient (quot)
  );

  assign sts.timeout_hit = elapsed_ext >= timeout_ext;
  assign sts.den_bad     = dur_sum <= VW'(DEN_OFS);
  assign sts.div_done    = div_done;

  // snap window, then clamp
  assign snap_low_ext  = {{TW{1'b0}}, snap_low};
  assign snap_high_ext = {{TW{1'b0}}, snap_high};
  assign snapped = ((quot > snap_low_ext) && (quot < snap_high_ext))
                   ? {{TW{1'b0}}, snap_target} : quot;
  assign sat_high = snapped > {{TW{1'b0}}, PPM_MAX};

  always_comb begin
    if (neg) begin
      ppm_calc = '0;
      st_calc  = (quot != '0) ? ST_SAT : ST_OK;
    end else if (sat_high) begin
      ppm_calc = PPM_MAX;
      st_calc  = ST_SAT;
    end else begin
      ppm_calc = snapped[PPM_W-1:0];
      st_calc  = ST_OK;
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.load_timeout) begin
      ppm       <= '0;
      high_time <= '0;
      low_time  <= '0;
      status    <= ST_TIMEOUT;
    end else if (cmd.load_bad) begin
      ppm       <= '0;
      high_time <= high_ext[OUT_T_W-1:0];
      low_time  <= low_ext[OUT_T_W-1:0];
      status    <= ST_BADPERIOD;
    end else if (cmd.load_ok) begin
      ppm       <= ppm_calc;
      high_time <= high_ext[OUT_T_W-1:0];
      low_time  <= low_ext[OUT_T_W-1:0];
      status    <= st_calc;
    end
  end

endmodule

/* hw/rtl/pcd_ctrl.sv */
// ----------------------------------------------------------------------------
// pcd_ctrl: controller of the period decoder
// measurement phases, compute sequencing and the output valid flag
// ----------------------------------------------------------------------------
module pcd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              func,
  input  logic              pin_level,
  output logic              out_valid,
  input  logic              out_ready,
  output pcd_pkg::pcd_cmd_t cmd,
  input  pcd_pkg::pcd_sts_t sts
);

  import pcd_pkg::*;

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_WAIT_LOW  = 3'd1;
  localparam logic [2:0] S_WAIT_HIGH = 3'd2;
  localparam logic [2:0] S_TIME_HIGH = 3'd3;
  localparam logic [2:0] S_TIME_LOW  = 3'd4;
  localparam logic [2:0] S_MUL       = 3'd5;
  localparam logic [2:0] S_DIV       = 3'd6;
  localparam logic [2:0] S_DONE      = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_free;
  logic       measuring;
  logic       accept;
  logic       load;

  assign out_free  = !out_valid || out_ready;
  assign measuring = state inside {S_IDLE, S_WAIT_LOW, S_WAIT_HIGH, S_TIME_HIGH, S_TIME_LOW};
  // only a timeout tick needs the output slot at once
  assign in_ready  = measuring && (out_free || func || (state == S_IDLE) || !sts.timeout_hit);
  assign accept    = in_valid && in_ready;
  assign load      = cmd.load_timeout || cmd.load_bad || cmd.load_ok;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE, S_WAIT_LOW, S_WAIT_HIGH, S_TIME_HIGH, S_TIME_LOW: begin
        if (accept) begin
          if (func) begin
            cmd.clear  = 1'b1;
            state_next = S_WAIT_LOW;
          end else if (state != S_IDLE) begin
            if (sts.timeout_hit) begin
              cmd.load_timeout = 1'b1;
              state_next       = S_IDLE;
            end else begin
              cmd.tick = 1'b1;
              case (state)
                S_WAIT_LOW: begin
                  if (!pin_level) state_next = S_WAIT_HIGH;
                end
                S_WAIT_HIGH: begin
                  if (pin_level) begin
                    cmd.cap_high = 1'b1;
                    state_next   = S_TIME_HIGH;
                  end
                end
                S_TIME_HIGH: begin
                  if (!pin_level) begin
                    cmd.cap_low = 1'b1;
                    state_next  = S_TIME_LOW;
                  end
                end
                S_TIME_LOW: begin
                  if (pin_level) begin
                    cmd.cap_end = 1'b1;
                    state_next  = S_MUL;
                  end
                end
                default: state_next = S_IDLE;
              endcase
            end
          end
        end
      end
      S_MUL: begin
        if (sts.den_bad) begin
          if (out_free) begin
            cmd.load_bad = 1'b1;
            state_next   = S_IDLE;
          end
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end
      end
      S_DIV: begin
        if (sts.div_done) state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.load_ok = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* hw/rtl/pwm_co2_period_decoder_top.sv */
// ----------------------------------------------------------------------------
// pwm_co2_period_decoder_top: pwm duty cycle to co2 ppm decoder
// times one high and one low phase of the sensor pwm and converts them to ppm
// ----------------------------------------------------------------------------
// timing: a timeout result is valid in the cycle after its tick; a period
//   result goes through the multiply state and, unless the period is bad, the
//   bit-serial divider and the done state, and loads once the output is free
// throughput: one item per cycle while measuring, unless a timeout tick waits
//   on a stalled result; input is held off from the closing tick to the load
// reset: synchronous, active high; idle, timers cleared, registers to defaults
module pwm_co2_period_decoder_top #(
  parameter int TIME_WIDTH = pcd_pkg::TIME_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // item channel in
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          func,
  input  logic                          pin_level,
  // result channel out
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pcd_pkg::PPM_W-1:0]     ppm,
  output logic [pcd_pkg::OUT_T_W-1:0]   high_time,
  output logic [pcd_pkg::OUT_T_W-1:0]   low_time,
  output logic [pcd_pkg::STATUS_W-1:0]  status,
  // register write port
  input  logic                          cfg_wr_en,
  input  logic [pcd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pcd_pkg::CFG_W-1:0]     cfg_wdata
);

  import pcd_pkg::*;

  // command and status between the two halves
  pcd_cmd_t cmd;
  pcd_sts_t sts;

  // controller: measurement phases, divider sequencing, output handshake
  pcd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .pin_level (pin_level),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // datapath: timers, multiply, serial divide, snap and clamp, result registers
  pcd_dpath #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .ppm       (ppm),
    .high_time (high_time),
    .low_time  (low_time),
    .status    (status)
  );

endmodule

/* hw/rtl/pcd_checker.sv */
// ----------------------------------------------------------------------------
// pcd_checker: port-level checks of the period decoder
// result ranges, status consistency and output hold under stall
// ----------------------------------------------------------------------------
module pcd_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [pcd_pkg::PPM_W-1:0]     ppm,
  input logic [pcd_pkg::OUT_T_W-1:0]   high_time,
  input logic [pcd_pkg::OUT_T_W-1:0]   low_time,
  input logic [pcd_pkg::STATUS_W-1:0]  status
);

  import pcd_pkg::*;

  // no result straight after reset
  a_rst_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(ppm) && $stable(status)
      && $stable(high_time) && $stable(low_time))
    else $error("stalled result changed");

  // ppm stays in range
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ppm <= PPM_MAX)
    else $error("ppm above full range");

  // timeout carries no measurement
  a_timeout: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_TIMEOUT |-> ppm == '0 && high_time == '0 && low_time == '0)
    else $error("timeout result not cleared");

  // bad period reports zero ppm
  a_badper: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_BADPERIOD |-> ppm == '0)
    else $error("bad period with non-zero ppm");

endmodule

bind pwm_co2_period_decoder_top pcd_checker u_pcd_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .ppm       (ppm),
  .high_time (high_time),
  .low_time  (low_time),
  .status    (status)
);

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the pwm co2 period decoder
// drives start and tick items with random gaps, predicts every reading from
// the sequence of accepted items and checks each returned reading field by
// field; several register settings are visited, the extremes among them
// ----------------------------------------------------------------------------
module testbench;
  import pcd_pkg::*;

  // time counters of the decoder at its default width
  localparam int TW = TIME_WIDTH_DEF;

  // item function codes
  localparam logic FUNC_TICK  = 1'b0;
  localparam logic FUNC_START = 1'b1;

  // cycles allowed after the last reading for the divider to wind down
  localparam int SETTLE_CYCLES = 64;
  localparam int MAX_REPORTS   = 10;
  localparam longint LIMIT_TIME = 64'd10_000_000;

  // one stimulus item and one decoder reading
  typedef struct packed {
    logic func;
    logic level;
  } pwm_item_t;

  typedef struct packed {
    logic [PPM_W-1:0]    ppm;
    logic [OUT_T_W-1:0]  high_time;
    logic [OUT_T_W-1:0]  low_time;
    logic [STATUS_W-1:0] status;
  } reading_t;

  // measurement progress as the decoder should see it
  typedef enum logic [2:0] {
    MP_IDLE,
    MP_WAIT_LOW,
    MP_WAIT_HIGH,
    MP_TIME_HIGH,
    MP_TIME_LOW
  } meas_phase_t;

  // ports of the decoder, its inputs all known from time zero
  logic                 clk;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  logic                 func      = 1'b0;
  logic                 pin_level = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [PPM_W-1:0]     ppm;
  logic [OUT_T_W-1:0]   high_time;
  logic [OUT_T_W-1:0]   low_time;
  logic [STATUS_W-1:0]  status;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  // items waiting to be sent and readings waiting to come back
  pwm_item_t   items_to_send[$];
  reading_t    readings_due[$];
  int unsigned items_made;
  int unsigned mismatch_count;

  // handshake bookkeeping shared between the edges
  bit          item_taken;
  pwm_item_t   next_item;
  int unsigned send_hold;
  int unsigned send_calm;
  int unsigned ready_hold;
  int unsigned ready_calm;

  // predicted decoder state and register copies
  meas_phase_t    mphase    = MP_IDLE;
  logic [TW-1:0]  elapsed   = '0;
  logic [TW-1:0]  high_mark = '0;
  logic [TW-1:0]  low_mark  = '0;
  logic [TW-1:0]  high_len  = '0;
  logic [CFG_W-1:0] timeout_reg    = TIMEOUT_RST;
  logic [PPM_W-1:0] full_scale_reg = FULL_SCALE_RST;
  logic [PPM_W-1:0] snap_lo_reg    = SNAP_LOW_RST;
  logic [PPM_W-1:0] snap_hi_reg    = SNAP_HIGH_RST;
  logic [PPM_W-1:0] snap_to_reg    = SNAP_TARGET_RST;

  pwm_co2_period_decoder_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .pin_level (pin_level),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ppm       (ppm),
    .high_time (high_time),
    .low_time  (low_time),
    .status    (status),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly back to back, now and then a few cycles, rarely a long pause
  function automatic int unsigned draw_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // works out the reading, if any, that one accepted item gives
  task automatic predict_reading(input logic f, input logic lvl);
    logic [TW-1:0] now;
    logic [TW-1:0] low_len;
    longint        num;
    longint        den;
    longint        q;
    reading_t      r;
    if (f == FUNC_START) begin
      // a start always rearms, even in the middle of a measurement
      mphase    = MP_WAIT_LOW;
      elapsed   = '0;
      high_mark = '0;
      low_mark  = '0;
      high_len  = '0;
      return;
    end
    // ticks while idle are ignored
    if (mphase == MP_IDLE) return;
    if (elapsed >= timeout_reg) begin
      mphase      = MP_IDLE;
      r.ppm       = '0;
      r.high_time = '0;
      r.low_time  = '0;
      r.status    = ST_TIMEOUT;
      readings_due.push_back(r);
      return;
    end
    now = elapsed;
    // elapsed counter sticks at its maximum
    if (elapsed != '1) elapsed = elapsed + 1'b1;
    case (mphase)
      MP_WAIT_LOW: begin
        if (!lvl) mphase = MP_WAIT_HIGH;
      end
      MP_WAIT_HIGH: begin
        if (lvl) begin
          high_mark = now;
          mphase    = MP_TIME_HIGH;
        end
      end
      MP_TIME_HIGH: begin
        if (!lvl) begin
          low_mark = now;
          high_len = now - high_mark;
          mphase   = MP_TIME_LOW;
        end
      end
      MP_TIME_LOW: begin
        if (lvl) begin
          low_len     = now - low_mark;
          mphase      = MP_IDLE;
          r.high_time = OUT_T_W'(high_len);
          r.low_time  = OUT_T_W'(low_len);
          num = longint'(high_len) - NUM_OFS;
          den = longint'(high_len) + longint'(low_len) - DEN_OFS;
          if (den <= 0) begin
            r.ppm    = '0;
            r.status = ST_BADPERIOD;
          end else begin
            // signed division truncates toward zero; snap before clamping
            q = longint'(full_scale_reg) * num / den;
            if (q > longint'(snap_lo_reg) && q < longint'(snap_hi_reg))
              q = longint'(snap_to_reg);
            if (q < 0) begin
              r.ppm    = '0;
              r.status = ST_SAT;
            end else if (q > longint'(PPM_MAX)) begin
              r.ppm    = PPM_MAX;
              r.status = ST_SAT;
            end else begin
              r.ppm    = PPM_W'(q);
              r.status = ST_OK;
            end
          end
          readings_due.push_back(r);
        end
      end
      default: mphase = MP_IDLE;
    endcase
  endtask

  function automatic void log_fault(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("%s", msg);
  endfunction

  // rising edge: note accepted items and register writes, check readings
  always @(posedge clk) begin
    reading_t want;
    item_taken = !rst && in_valid && in_ready;
    if (item_taken) predict_reading(func, pin_level);
    if (!rst && cfg_wr_en) begin
      case (cfg_index)
        REG_TIMEOUT:     timeout_reg    = cfg_wdata;
        REG_FULL_SCALE:  full_scale_reg = cfg_wdata[PPM_W-1:0];
        REG_SNAP_LOW:    snap_lo_reg    = cfg_wdata[PPM_W-1:0];
        REG_SNAP_HIGH:   snap_hi_reg    = cfg_wdata[PPM_W-1:0];
        REG_SNAP_TARGET: snap_to_reg    = cfg_wdata[PPM_W-1:0];
        default: ;
      endcase
    end
    if (!rst && out_valid && out_ready) begin
      if (readings_due.size() == 0) begin
        log_fault($sformatf("unexpected reading: ppm=%0d hi=%0d lo=%0d st=%0d",
                            ppm, high_time, low_time, status));
      end else begin
        want = readings_due.pop_front();
        if (want.ppm !== ppm || want.high_time !== high_time ||
            want.low_time !== low_time || want.status !== status)
          log_fault($sformatf(
            "reading mismatch: want ppm=%0d hi=%0d lo=%0d st=%0d, got %0d %0d %0d %0d",
            want.ppm, want.high_time, want.low_time, want.status,
            ppm, high_time, low_time, status));
      end
    end
  end

  // item driver: falling edge, holds each item until it is taken
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !item_taken) begin
      // item still on offer, payload held
    end else if (send_hold != 0) begin
      send_hold--;
      in_valid <= 1'b0;
    end else if (items_to_send.size() != 0) begin
      next_item = items_to_send.pop_front();
      func      <= next_item.func;
      pin_level <= next_item.level;
      in_valid  <= 1'b1;
      if (send_calm != 0) begin
        send_calm--;
      end else begin
        send_hold = draw_gap();
        // now and then a stretch with no gaps at all
        if ($urandom_range(0, 99) == 0) send_calm = $urandom_range(20, 80);
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // reading receiver: stalls independent of what the decoder is doing
  always @(negedge clk) begin
    if (ready_hold != 0) begin
      ready_hold--;
      out_ready <= 1'b0;
    end else if (ready_calm != 0) begin
      ready_calm--;
      out_ready <= 1'b1;
    end else begin
      out_ready <= 1'b1;
      ready_hold = draw_gap();
      if ($urandom_range(0, 199) == 0) ready_calm = $urandom_range(30, 120);
    end
  end

  task automatic queue_item(input logic f, input logic lvl);
    pwm_item_t it;
    it.func  = f;
    it.level = lvl;
    items_to_send.push_back(it);
    items_made++;
  endtask

  // a start followed by a clean pwm period: highs ignored before arming,
  // arming lows, a high run, a low run and the closing high
  task automatic queue_measurement(input int pre_hi, input int arm_lo,
                                   input int hi, input int lo);
    queue_item(FUNC_START, $urandom_range(0, 1));
    repeat (pre_hi) queue_item(FUNC_TICK, 1'b1);
    repeat (arm_lo) queue_item(FUNC_TICK, 1'b0);
    repeat (hi) queue_item(FUNC_TICK, 1'b1);
    repeat (lo) queue_item(FUNC_TICK, 1'b0);
    queue_item(FUNC_TICK, 1'b1);
  endtask

  // mostly clean periods with short runs, some long ones, some noise
  task automatic queue_random_burst();
    int unsigned n;
    if ($urandom_range(0, 99) < 78) begin
      if ($urandom_range(0, 24) == 0)
        queue_measurement(0, $urandom_range(1, 3),
                          $urandom_range(25, 300), $urandom_range(25, 300));
      else
        queue_measurement(($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0,
                          $urandom_range(1, 3),
                          $urandom_range(1, $urandom_range(2, 14)),
                          $urandom_range(1, $urandom_range(2, 45)));
    end else begin
      // stray or restarting starts and random pin levels
      if ($urandom_range(0, 1) != 0) queue_item(FUNC_START, $urandom_range(0, 1));
      n = $urandom_range(0, 10);
      repeat (n) queue_item(FUNC_TICK, $urandom_range(0, 1));
    end
  endtask

  // writes all five registers on consecutive cycles
  task automatic write_regs(input int t, input int fs, input int lo,
                            input int hi, input int tg);
    logic [CFG_IDX_W-1:0] idx[5];
    int                   val[5];
    idx = '{REG_TIMEOUT, REG_FULL_SCALE, REG_SNAP_LOW, REG_SNAP_HIGH, REG_SNAP_TARGET};
    val = '{t, fs, lo, hi, tg};
    for (int i = 0; i < 5; i++) begin
      @(negedge clk);
      cfg_wr_en <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= CFG_W'(val[i]);
    end
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // everything sent and returned, then room for the divider to finish
  task automatic wait_idle();
    do @(posedge clk);
    while (items_to_send.size() != 0 || in_valid || readings_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    int unsigned budget;
    int unsigned snap_base;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // directed checks with the reset register values
    queue_item(FUNC_TICK, 1'b1);              // tick while idle, no reading
    queue_measurement(1, 1, 1, 1);            // early high ignored, bad period
    queue_item(FUNC_START, 1'b1);             // measurement abandoned part way
    queue_item(FUNC_TICK, 1'b0);
    queue_item(FUNC_TICK, 1'b1);
    queue_measurement(0, 1, 1, 4);            // restart, negative ppm clamps to 0
    queue_measurement(0, 2, 5, 1);            // plain ok reading
    wait_idle();

    // register settings: extremes first, then random ones
    // the last burst of each setting may overrun its budget, at times by a long period
    for (int p = 0; p < 9; p++) begin
      case (p)
        0: begin
          write_regs(1, 0, 10000, 0, 0);      // everything times out
          budget = 45;
        end
        1: begin
          write_regs(65535, 10000, 0, 10000, 10000);  // widest snap window
          budget = 110;
        end
        2: begin
          write_regs(40, 10000, 385, 399, 400);
          budget = 100;
        end
        3: begin
          write_regs(TIMEOUT_RST, FULL_SCALE_RST, SNAP_LOW_RST,
                     SNAP_HIGH_RST, SNAP_TARGET_RST);
          budget = 110;
        end
        default: begin
          snap_base = $urandom_range(0, 9000);
          write_regs(($urandom_range(0, 3) == 0) ? $urandom_range(1, 60)
                                                 : $urandom_range(100, 65535),
                     $urandom_range(0, 10000), snap_base,
                     snap_base + $urandom_range(0, 1000), $urandom_range(0, 10000));
          budget = 85;
        end
      endcase
      items_made = 0;
      while (items_made < budget) queue_random_burst();
      // a short closing period always leaves the decoder idle
      queue_measurement(0, 1, 1, 1);
      wait_idle();
    end

    if (mismatch_count == 0 && readings_due.size() == 0) begin
      $display("pwm_co2_period_decoder_top test passed");
    end else begin
      $display("pwm_co2_period_decoder_top test failed");
    end
    $finish;
  end

  // hard stop if the decoder hangs
  initial begin
    #(LIMIT_TIME);
    $display("pwm_co2_period_decoder_top test failed");
    $finish;
  end

endmodule
